>>> rtl/alp_pkg.sv
// Shared types and codes for the address lease pool.
// Used by address_lease_pool, alp_lease and the bench; depends on nothing.
package alp_pkg;

    // entry state codes
    localparam logic [1:0] ST_FREE     = 2'd0;
    localparam logic [1:0] ST_PENDING  = 2'd1;
    localparam logic [1:0] ST_OCCUPIED = 2'd2;
    localparam logic [1:0] ST_EXPIRED  = 2'd3;

    // message type codes
    localparam logic [1:0] OP_DISCOVER = 2'd0;
    localparam logic [1:0] OP_REQUEST  = 2'd1;

    // receiver codes (the two unused codes behave as another server)
    localparam logic [1:0] RCV_SELF  = 2'd0;
    localparam logic [1:0] RCV_BCAST = 2'd1;

    // reply codes
    localparam logic [1:0] RPL_OFFER = 2'd0;
    localparam logic [1:0] RPL_NAK   = 2'd1;
    localparam logic [1:0] RPL_ACK   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_POOL_COUNT    = 2'd0;
    localparam logic [1:0] CFG_DEFAULT_LEASE = 2'd1;
    localparam logic [1:0] CFG_MAX_LEASE     = 2'd2;
    localparam logic [1:0] CFG_MIN_LEASE     = 2'd3;

    localparam logic [8:0]  RST_POOL_COUNT    = 9'd256;
    localparam logic [31:0] RST_DEFAULT_LEASE = 32'd100;
    localparam logic [31:0] RST_MAX_LEASE     = 32'd1000;
    localparam logic [31:0] RST_MIN_LEASE     = 32'd10;

    // status and expiry word kept per entry
    localparam int TIME_W = 32;
    localparam int META_W = TIME_W + 2;

    typedef struct packed {
        logic [31:0] default_lease;
        logic [31:0] max_lease;
        logic [31:0] min_lease;
    } t_lease_cfg;

endpackage

>>> rtl/alp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module alp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> rtl/alp_lease.sv
// Lease expiry unit: clamps a requested expiry to the configured lease limits.
// Depends on alp_pkg. Two register stages: sums and difference, then selection.
module alp_lease (
    input  logic                i_clk,
    input  logic                i_load,
    input  logic [31:0]         i_now,
    input  logic [31:0]         i_req,
    input  alp_pkg::t_lease_cfg i_cfg,
    output logic [31:0]         o_lease
);

    logic               r_zero;
    logic [31:0]        r_req;
    logic signed [32:0] r_diff;
    logic [31:0]        r_sum_def;
    logic [31:0]        r_sum_min;
    logic [31:0]        r_sum_max;
    logic signed [32:0] w_min;
    logic signed [32:0] w_max;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // stage one: hold the sums and the signed distance to the request
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_zero    <= (i_req == 32'd0);
            r_req     <= i_req;
            r_diff    <= $signed({1'b0, i_req}) - $signed({1'b0, i_now});
            r_sum_def <= sat_add(i_now, i_cfg.default_lease);
            r_sum_min <= sat_add(i_now, i_cfg.min_lease);
            r_sum_max <= sat_add(i_now, i_cfg.max_lease);
        end
    end

    assign w_min = $signed({1'b0, i_cfg.min_lease});
    assign w_max = $signed({1'b0, i_cfg.max_lease});

    // stage two: pick the clamped value
    always_ff @(posedge i_clk) begin
        priority if (r_zero) begin
            o_lease <= r_sum_def;
        end else if (r_diff >= w_min && r_diff <= w_max) begin
            o_lease <= r_req;
        end else if (r_diff < w_min) begin
            o_lease <= r_sum_min;
        end else begin
            o_lease <= r_sum_max;
        end
    end

endmodule

>>> rtl/address_lease_pool.sv
// Address lease pool top level: message handshake, pool sweep and reply beat.
// Depends on alp_pkg, alp_ram (entry state stores) and alp_lease (expiry clamp).
//
// Each message beat handles one lease message against a pool of addresses
// numbered 1..n, n = min(pool_count, POOL_SIZE). The status and expiry of
// every entry sit in one synchronous RAM and the owner ids in a second; a
// message sweeps the n live entries one per cycle, ageing each (lapsed
// pending entries go free, lapsed occupied ones go expired), freeing the
// sender's pending entries for a request aimed at another server, and
// collecting the discover candidates (sender's own entry, lowest free,
// lowest expired) on the way. A message therefore occupies the block for
// its prepare step, the sweep and the decision; a request to this server
// needs one more read of the named entry. The sweep through the state RAM
// sets how long a message takes. A finished reply waits in the output
// register while the next message is taken. After reset a clearing pass
// sets all min(POOL_SIZE, 511) entries free with zero expiry; no message
// is accepted during it, configuration writes are. Configuration must be
// written between messages only; the block itself does not enforce this.
module address_lease_pool #(
    parameter int POOL_SIZE    = 256,
    parameter int HOST_ID_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // message in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // sender_id[15:0], now[47:16],
                                       // req_address[63:48], req_expiry[95:64]
    input  logic [3:0]  s_axis_tuser,  // op[1:0], receiver_kind[3:2]
    // reply out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // dest_id[15:0], address[31:16],
                                       // expiry[63:32]
    output logic [1:0]  m_axis_tuser,  // reply_kind[1:0]
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // pool_count is nine bits wide, so entries above 511 can never be used
    localparam int DEPTH = (POOL_SIZE < 511) ? POOL_SIZE : 511;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    // sender ids are 16 bits on the port, so owners never need more
    localparam int OWN_W = (HOST_ID_BITS < 16) ? HOST_ID_BITS : 16;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_SWEEP,
        S_DECIDE,
        S_REQ_WR
    } t_state;

    t_state r_state;
    t_state n_state;

    // configuration registers
    logic [8:0]  r_pool_count;
    logic [31:0] r_default_lease;
    logic [31:0] r_max_lease;
    logic [31:0] r_min_lease;
    alp_pkg::t_lease_cfg w_lease_cfg;

    // message held for the duration of its handling
    logic             r_disc;
    logic             r_rel;
    logic             r_req;
    logic [OWN_W-1:0] r_sender;
    logic [31:0]      r_now;
    logic [15:0]      r_raddr;
    logic [31:0]      r_rexp;
    logic [CW-1:0]    r_n;

    // sweep control
    logic [CW-1:0] r_idx;
    logic          r_pvld;
    logic [AW-1:0] r_pidx;

    // discover candidates
    logic          r_own_hit;
    logic [AW-1:0] r_own_idx;
    logic          r_free_hit;
    logic [AW-1:0] r_free_idx;
    logic          r_exp_hit;
    logic [AW-1:0] r_exp_idx;

    // reply register
    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [15:0] r_out_dest;
    logic [15:0] r_out_addr;
    logic [31:0] r_out_exp;

    // RAM ports
    logic                      w_rd_en;
    logic [AW-1:0]             w_rd_addr;
    logic                      w_meta_we;
    logic                      w_own_we;
    logic [AW-1:0]             w_wr_addr;
    logic [alp_pkg::META_W-1:0] w_meta_wdata;
    logic [alp_pkg::META_W-1:0] w_meta_rdata;
    logic [OWN_W-1:0]          w_own_rdata;

    logic [31:0]   w_lease;
    logic          w_issue;
    logic          w_out_free;
    logic          w_emit;
    logic [1:0]    w_emit_kind;
    logic [15:0]   w_emit_addr;
    logic [31:0]   w_emit_exp;
    logic [AW-1:0] w_pick;
    logic [AW-1:0] w_req_idx;
    logic          w_in_range;
    logic          w_accept;
    logic [CW-1:0] w_n;

    // entry ageing on read data
    logic [1:0]  w_rd_st;
    logic [31:0] w_rd_exp;
    logic        w_lapsed;
    logic [1:0]  w_aged_st;
    logic [31:0] w_aged_exp;
    logic        w_own_match;
    logic [1:0]  w_wb_st;
    logic [31:0] w_wb_exp;

    assign w_lease_cfg.default_lease = r_default_lease;
    assign w_lease_cfg.max_lease     = r_max_lease;
    assign w_lease_cfg.min_lease     = r_min_lease;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_n           = (r_pool_count > 9'(DEPTH)) ? CW'(DEPTH) : CW'(r_pool_count);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_exp, r_out_addr, r_out_dest};
    assign m_axis_tuser  = r_out_kind;

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_issue    = (r_idx < r_n);

    assign w_rd_st     = w_meta_rdata[alp_pkg::META_W-1 -: 2];
    assign w_rd_exp    = w_meta_rdata[alp_pkg::TIME_W-1:0];
    assign w_lapsed    = (w_rd_exp <= r_now);
    assign w_own_match = (w_own_rdata == r_sender);

    assign w_pick     = r_own_hit ? r_own_idx : (r_free_hit ? r_free_idx : r_exp_idx);
    assign w_req_idx  = AW'(r_raddr - 16'd1);
    assign w_in_range = (r_raddr != 16'd0) && (r_raddr <= 16'(r_n));

    // age one entry, then apply the release of a request for another server
    always_comb begin
        w_aged_st  = w_rd_st;
        w_aged_exp = w_rd_exp;
        if (w_rd_st == alp_pkg::ST_PENDING && w_lapsed) begin
            w_aged_st  = alp_pkg::ST_FREE;
            w_aged_exp = 32'd0;
        end else if (w_rd_st == alp_pkg::ST_OCCUPIED && w_lapsed) begin
            w_aged_st  = alp_pkg::ST_EXPIRED;
            w_aged_exp = 32'd0;
        end
        w_wb_st  = w_aged_st;
        w_wb_exp = w_aged_exp;
        if (r_rel && w_aged_st == alp_pkg::ST_PENDING && w_own_match) begin
            w_wb_st  = alp_pkg::ST_FREE;
            w_wb_exp = 32'd0;
        end
    end

    // RAM port steering, next state and reply launch
    always_comb begin
        n_state      = r_state;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_idx[AW-1:0];
        w_meta_we    = 1'b0;
        w_own_we     = 1'b0;
        w_wr_addr    = r_pidx;
        w_meta_wdata = {w_wb_st, w_wb_exp};
        w_emit       = 1'b0;
        w_emit_kind  = alp_pkg::RPL_NAK;
        w_emit_addr  = r_raddr;
        w_emit_exp   = 32'd0;
        unique case (r_state)
            S_CLEAR: begin
                w_meta_we    = 1'b1;
                w_wr_addr    = r_idx[AW-1:0];
                w_meta_wdata = {alp_pkg::ST_FREE, 32'd0};
                if (r_idx == CW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                w_rd_en   = w_issue;
                w_meta_we = r_pvld;
                if (!w_issue && !r_pvld) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                priority if (r_disc) begin
                    if (!(r_own_hit || r_free_hit || r_exp_hit)) begin
                        n_state = S_IDLE;
                    end else if (w_out_free) begin
                        w_meta_we    = 1'b1;
                        w_own_we     = 1'b1;
                        w_wr_addr    = w_pick;
                        w_meta_wdata = {alp_pkg::ST_PENDING, w_lease};
                        w_emit       = 1'b1;
                        w_emit_kind  = alp_pkg::RPL_OFFER;
                        w_emit_addr  = 16'(w_pick) + 16'd1;
                        w_emit_exp   = w_lease;
                        n_state      = S_IDLE;
                    end
                end else if (r_req) begin
                    if (w_in_range) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_req_idx;
                        n_state   = S_REQ_WR;
                    end else if (w_out_free) begin
                        w_emit  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_REQ_WR: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                    if (w_rd_st != alp_pkg::ST_FREE && w_own_match) begin
                        w_meta_we    = 1'b1;
                        w_wr_addr    = w_req_idx;
                        w_meta_wdata = {alp_pkg::ST_OCCUPIED, w_lease};
                        w_emit_kind  = alp_pkg::RPL_ACK;
                        w_emit_exp   = w_lease;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_idx           <= '0;
            r_pvld          <= 1'b0;
            r_out_valid     <= 1'b0;
            r_pool_count    <= alp_pkg::RST_POOL_COUNT;
            r_default_lease <= alp_pkg::RST_DEFAULT_LEASE;
            r_max_lease     <= alp_pkg::RST_MAX_LEASE;
            r_min_lease     <= alp_pkg::RST_MIN_LEASE;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    alp_pkg::CFG_POOL_COUNT:    r_pool_count    <= i_cfg_data[8:0];
                    alp_pkg::CFG_DEFAULT_LEASE: r_default_lease <= i_cfg_data;
                    alp_pkg::CFG_MAX_LEASE:     r_max_lease     <= i_cfg_data;
                    alp_pkg::CFG_MIN_LEASE:     r_min_lease     <= i_cfg_data;
                    default: ;
                endcase
            end

            // reply register: load a new beat, or drop the one taken
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_out_kind  <= w_emit_kind;
                r_out_dest  <= 16'(r_sender);
                r_out_addr  <= w_emit_addr;
                r_out_exp   <= w_emit_exp;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= (n_state == S_IDLE) ? '0 : r_idx + CW'(1);
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_disc     <= (s_axis_tuser[1:0] == alp_pkg::OP_DISCOVER) &&
                                      (s_axis_tuser[3:2] == alp_pkg::RCV_BCAST);
                        r_rel      <= (s_axis_tuser[1:0] == alp_pkg::OP_REQUEST) &&
                                      (s_axis_tuser[3:2] != alp_pkg::RCV_SELF) &&
                                      (s_axis_tuser[3:2] != alp_pkg::RCV_BCAST);
                        r_req      <= (s_axis_tuser[1:0] == alp_pkg::OP_REQUEST) &&
                                      (s_axis_tuser[3:2] == alp_pkg::RCV_SELF);
                        r_sender   <= s_axis_tdata[OWN_W-1:0];
                        r_now      <= s_axis_tdata[47:16];
                        r_raddr    <= s_axis_tdata[63:48];
                        r_rexp     <= s_axis_tdata[95:64];
                        r_n        <= w_n;
                        r_idx      <= '0;
                        r_pvld     <= 1'b0;
                        r_own_hit  <= 1'b0;
                        r_free_hit <= 1'b0;
                        r_exp_hit  <= 1'b0;
                    end
                end
                S_SWEEP: begin
                    r_pvld <= w_rd_en;
                    r_pidx <= r_idx[AW-1:0];
                    if (w_rd_en) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    // collect the lowest candidate of each kind
                    if (r_pvld && r_disc) begin
                        if (!r_own_hit && w_aged_st != alp_pkg::ST_FREE && w_own_match) begin
                            r_own_hit <= 1'b1;
                            r_own_idx <= r_pidx;
                        end
                        if (!r_free_hit && w_aged_st == alp_pkg::ST_FREE) begin
                            r_free_hit <= 1'b1;
                            r_free_idx <= r_pidx;
                        end
                        if (!r_exp_hit && w_aged_st == alp_pkg::ST_EXPIRED) begin
                            r_exp_hit <= 1'b1;
                            r_exp_idx <= r_pidx;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    alp_ram #(
        .WIDTH(alp_pkg::META_W),
        .DEPTH(DEPTH)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (w_meta_we),
        .i_waddr (w_wr_addr),
        .i_wdata (w_meta_wdata),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_meta_rdata)
    );

    alp_ram #(
        .WIDTH(OWN_W),
        .DEPTH(DEPTH)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (w_own_we),
        .i_waddr (w_wr_addr),
        .i_wdata (r_sender),
        .i_re    (w_rd_en),
        .i_raddr (w_rd_addr),
        .o_rdata (w_own_rdata)
    );

    alp_lease u_lease (
        .i_clk   (i_clk),
        .i_load  (r_state == S_PREP),
        .i_now   (r_now),
        .i_req   (r_rexp),
        .i_cfg   (w_lease_cfg),
        .o_lease (w_lease)
    );

    // the sweep never writes back the entry it is reading in the same cycle
    a_sweep_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && w_rd_en && w_meta_we) |-> (w_rd_addr != w_wr_addr))
        else $error("sweep read and write-back hit the same entry");

    // the sweep leaves only after visiting every live entry
    a_sweep_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && n_state == S_DECIDE) |-> (r_idx == r_n))
        else $error("sweep ended early");

    // offers and acknowledges name a live address
    a_reply_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_emit_kind != alp_pkg::RPL_NAK) |=>
            (r_out_addr != 16'd0 && r_out_addr <= 16'(r_n)))
        else $error("reply names an address outside the pool");

    // a reply is never overwritten before it is taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !w_emit)
        else $error("reply register overwritten while stalled");

endmodule

>>> tb/tb.sv
// Self-checking bench for address_lease_pool: drives lease messages and register writes.
// It predicts the offer, acknowledge and negative replies with its own copy of the pool.
// Depends on alp_pkg and address_lease_pool only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_N = 256;

    // selector values the block ignores or folds into another server
    localparam logic [1:0] OP_OTHER  = 2'd2;
    localparam logic [1:0] OP_SPARE  = 2'd3;
    localparam logic [1:0] RCV_OTHER = 2'd2;
    localparam logic [1:0] RCV_SPARE = 2'd3;

    // hold time between phases: one full sweep plus slack
    localparam int SETTLE_CYCLES = 600;
    // long receiver hold-off, well beyond two small-pool messages
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] sender;
        logic [1:0]  rcv;
        logic [31:0] now;
        logic [15:0] addr;
        logic [31:0] rexp;
    } t_lease_msg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] dest;
        logic [15:0] addr;
        logic [31:0] expiry;
    } t_lease_reply;

    // Shadow copy of the pool: ages, allocates and releases entries exactly as the
    // block should, and keeps the replies still owed in arrival order.
    class t_lease_ledger;
        logic [1:0]   status [1:POOL_N];
        logic [15:0]  owner  [1:POOL_N];
        logic [31:0]  expiry [1:POOL_N];
        logic [8:0]   pool_count;
        logic [31:0]  dflt_lease;
        logic [31:0]  max_lease;
        logic [31:0]  min_lease;
        t_lease_reply owed [$];
        int           errors;

        function new();
            for (int i = 1; i <= POOL_N; i++) begin
                status[i] = alp_pkg::ST_FREE;
                owner[i]  = '0;
                expiry[i] = '0;
            end
            pool_count = alp_pkg::RST_POOL_COUNT;
            dflt_lease = alp_pkg::RST_DEFAULT_LEASE;
            max_lease  = alp_pkg::RST_MAX_LEASE;
            min_lease  = alp_pkg::RST_MIN_LEASE;
            errors     = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                alp_pkg::CFG_POOL_COUNT:    pool_count = val[8:0];
                alp_pkg::CFG_DEFAULT_LEASE: dflt_lease = val;
                alp_pkg::CFG_MAX_LEASE:     max_lease  = val;
                alp_pkg::CFG_MIN_LEASE:     min_lease  = val;
                default: ;
            endcase
        endfunction

        function int live_count();
            return (pool_count > POOL_N) ? POOL_N : int'(pool_count);
        endfunction

        function int outstanding();
            return owed.size();
        endfunction

        // lowest address the host holds in any state but free, zero if none
        function int held_by(logic [15:0] host);
            for (int i = 1; i <= live_count(); i++)
                if (status[i] != alp_pkg::ST_FREE && owner[i] == host)
                    return i;
            return 0;
        endfunction

        function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        // clamp a requested expiry into [now + min, now + max], zero meaning default
        function logic [31:0] lease_end(logic [31:0] now, logic [31:0] req);
            longint d;
            if (req == '0)
                return sat_sum(now, dflt_lease);
            d = longint'(req) - longint'(now);
            if (longint'(min_lease) <= d && d <= longint'(max_lease))
                return req;
            if (d < longint'(min_lease))
                return sat_sum(now, min_lease);
            return sat_sum(now, max_lease);
        endfunction

        function void note_msg(t_lease_msg m);
            int           n;
            int           pick;
            int           first_free;
            int           first_exp;
            logic [1:0]   rcv;
            t_lease_reply r;
            n   = live_count();
            rcv = (m.rcv == RCV_SPARE) ? RCV_OTHER : m.rcv;

            // age the live entries first
            for (int i = 1; i <= n; i++) begin
                if (status[i] == alp_pkg::ST_PENDING && expiry[i] <= m.now) begin
                    status[i] = alp_pkg::ST_FREE;
                    expiry[i] = '0;
                end else if (status[i] == alp_pkg::ST_OCCUPIED && expiry[i] <= m.now) begin
                    status[i] = alp_pkg::ST_EXPIRED;
                    expiry[i] = '0;
                end
            end

            if (m.op == alp_pkg::OP_DISCOVER && rcv == alp_pkg::RCV_BCAST) begin
                pick       = 0;
                first_free = 0;
                first_exp  = 0;
                for (int i = 1; i <= n; i++) begin
                    if (status[i] != alp_pkg::ST_FREE && owner[i] == m.sender) begin
                        pick = i;
                        break;
                    end
                    if (status[i] == alp_pkg::ST_FREE && first_free == 0)
                        first_free = i;
                    if (status[i] == alp_pkg::ST_EXPIRED && first_exp == 0)
                        first_exp = i;
                end
                if (pick == 0)
                    pick = first_free;
                if (pick == 0)
                    pick = first_exp;
                if (pick != 0) begin
                    status[pick] = alp_pkg::ST_PENDING;
                    owner[pick]  = m.sender;
                    expiry[pick] = lease_end(m.now, m.rexp);
                    r.kind   = alp_pkg::RPL_OFFER;
                    r.dest   = m.sender;
                    r.addr   = 16'(pick);
                    r.expiry = expiry[pick];
                    owed.push_back(r);
                end
            end else if (m.op == alp_pkg::OP_REQUEST && rcv == RCV_OTHER) begin
                // sender chose another server: drop its pending offers, no reply
                for (int i = 1; i <= n; i++) begin
                    if (status[i] == alp_pkg::ST_PENDING && owner[i] == m.sender) begin
                        status[i] = alp_pkg::ST_FREE;
                        expiry[i] = '0;
                    end
                end
            end else if (m.op == alp_pkg::OP_REQUEST && rcv == alp_pkg::RCV_SELF) begin
                r.dest = m.sender;
                r.addr = m.addr;
                if (m.addr < 1 || int'(m.addr) > n || status[m.addr] == alp_pkg::ST_FREE ||
                    owner[m.addr] != m.sender) begin
                    r.kind   = alp_pkg::RPL_NAK;
                    r.expiry = '0;
                end else begin
                    status[m.addr] = alp_pkg::ST_OCCUPIED;
                    expiry[m.addr] = lease_end(m.now, m.rexp);
                    r.kind   = alp_pkg::RPL_ACK;
                    r.expiry = expiry[m.addr];
                end
                owed.push_back(r);
            end
        endfunction

        function void field_check(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_reply(t_lease_reply r);
            t_lease_reply e;
            if (owed.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected reply beat kind %0d dest 0x%0h addr %0d",
                         $time, r.kind, r.dest, r.addr);
                return;
            end
            e = owed.pop_front();
            field_check("reply_kind", 32'(e.kind), 32'(r.kind));
            field_check("dest_id", 32'(e.dest), 32'(r.dest));
            field_check("address", 32'(e.addr), 32'(r.addr));
            field_check("expiry", e.expiry, r.expiry);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // sender_id, now, req_address, req_expiry (low to high)
    logic [3:0]  s_axis_tuser;   // op, receiver_kind (low to high)
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // dest_id, address, expiry (low to high)
    logic [1:0]  m_axis_tuser;   // reply_kind
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    t_lease_ledger ledger = new();
    logic [31:0] clk_now;        // message time, mostly creeping forward
    int          replies_seen;
    int          burst_left;

    address_lease_pool i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop: the slowest legal run is well under a millisecond.
    initial begin
        #4_000_000;
        $display("tb failed");
        $finish;
    end

    // Check every reply beat against the oldest owed reply.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            ledger.check_reply({m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                                m_axis_tdata[63:32]});
            replies_seen++;
        end
    end

    // Reply sink: switch between randomly chosen stall patterns, and now and then
    // hold off for a long stretch so the block fills up and stalls its input.
    initial begin : reply_sink
        int mode;
        int left;
        int hold_at;
        int tick;
        m_axis_tready = 1'b0;
        mode    = 0;
        left    = 0;
        hold_at = 60;
        tick    = 0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (replies_seen >= hold_at) begin
                hold_at += 290;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(16, 80);
                end
                left--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= $urandom_range(0, 1);
                    2:       m_axis_tready <= (tick % 4 == 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Present one message and hold it until the block takes the beat; return on the
    // following falling edge with valid still high.
    task automatic drive_msg(input t_lease_msg m);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {m.rexp, m.addr, m.now, m.sender};
        s_axis_tuser  <= {m.rcv, m.op};
        do @(posedge i_clk); while (!s_axis_tready);
        ledger.note_msg(m);
        @(negedge i_clk);
    endtask

    task automatic directed(input logic [1:0] op, input logic [15:0] sender,
                            input logic [1:0] rcv, input logic [31:0] now,
                            input logic [15:0] addr, input logic [31:0] rexp);
        drive_msg('{op: op, sender: sender, rcv: rcv, now: now, addr: addr, rexp: rexp});
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        ledger.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic load_cfg(input logic [8:0] pool, input logic [31:0] dflt,
                            input logic [31:0] max_l, input logic [31:0] min_l);
        cfg_write(alp_pkg::CFG_POOL_COUNT, {23'd0, pool});
        cfg_write(alp_pkg::CFG_DEFAULT_LEASE, dflt);
        cfg_write(alp_pkg::CFG_MAX_LEASE, max_l);
        cfg_write(alp_pkg::CFG_MIN_LEASE, min_l);
        i_cfg_we <= 1'b0;
    endtask

    // Drop valid, wait for every owed reply, then let a full sweep pass so a
    // message with no reply has surely finished before the next register write.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (ledger.outstanding() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly well-formed traffic from a small set of hosts: discovers, requests
    // for the address the host holds, and releases; the rest is noise.
    function automatic t_lease_msg next_msg(input int host_base, input int host_span,
                                            input int step_max, input int exp_span);
        t_lease_msg m;
        int         pick;
        int         held;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 39) == 0)
            clk_now = $urandom;
        else
            clk_now = clk_now + $urandom_range(0, step_max);
        m.now    = clk_now;
        m.sender = 16'(host_base + $urandom_range(0, host_span));
        m.addr   = 16'($urandom_range(0, ledger.live_count() + 1));
        case ($urandom_range(0, 6))
            0, 1:    m.rexp = '0;
            2:       m.rexp = $urandom;
            default: m.rexp = clk_now + $urandom_range(0, exp_span) - exp_span / 4;
        endcase
        if (pick < 35) begin
            m.op  = alp_pkg::OP_DISCOVER;
            m.rcv = alp_pkg::RCV_BCAST;
        end else if (pick < 70) begin
            m.op  = alp_pkg::OP_REQUEST;
            m.rcv = alp_pkg::RCV_SELF;
            held  = ledger.held_by(m.sender);
            if (held != 0 && $urandom_range(0, 4) != 0)
                m.addr = 16'(held);
        end else if (pick < 80) begin
            m.op  = alp_pkg::OP_REQUEST;
            m.rcv = $urandom_range(0, 1) ? RCV_OTHER : RCV_SPARE;
        end else begin
            m.op     = 2'($urandom_range(0, 3));
            m.rcv    = 2'($urandom_range(0, 3));
            m.sender = 16'($urandom);
            m.addr   = 16'($urandom);
        end
        return m;
    endfunction

    // Random phase: bursts of back-to-back beats separated by random gaps.
    task automatic run_phase(input int count, input int host_base, input int host_span,
                             input int step_max, input int exp_span);
        int gap;
        for (int k = 0; k < count; k++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            drive_msg(next_msg(host_base, host_span, step_max, exp_span));
            burst_left--;
        end
        drain();
    endtask

    initial begin : stimulus
        int held;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = alp_pkg::CFG_POOL_COUNT;
        i_cfg_data    = '0;
        clk_now       = '0;
        replies_seen  = 0;
        burst_left    = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed run at the reset settings: first offer, own entry found again,
        // acknowledge inside the window, negative replies for address zero, out of
        // range and wrong owner, expiry clamped low, high and from a past time,
        // releases via another server and the folded receiver code, ignored
        // combinations, ageing, a request on an expired entry, saturating sums.
        directed(alp_pkg::OP_DISCOVER, 16'd1, alp_pkg::RCV_BCAST, 32'd0, 16'd0, 32'd0);
        directed(alp_pkg::OP_DISCOVER, 16'd1, alp_pkg::RCV_BCAST, 32'd5, 16'd0, 32'd60);
        directed(alp_pkg::OP_REQUEST, 16'd1, alp_pkg::RCV_SELF, 32'd10, 16'd1, 32'd40);
        directed(alp_pkg::OP_REQUEST, 16'd1, alp_pkg::RCV_SELF, 32'd11, 16'd0, 32'd0);
        directed(alp_pkg::OP_REQUEST, 16'd1, alp_pkg::RCV_SELF, 32'd11, 16'd257, 32'd0);
        directed(alp_pkg::OP_REQUEST, 16'd2, alp_pkg::RCV_SELF, 32'd12, 16'd1, 32'd0);
        directed(alp_pkg::OP_DISCOVER, 16'd2, alp_pkg::RCV_BCAST, 32'd12, 16'hFFFF, 32'd15);
        directed(alp_pkg::OP_DISCOVER, 16'd3, alp_pkg::RCV_BCAST, 32'd13, 16'd0, 32'd9000);
        directed(alp_pkg::OP_DISCOVER, 16'd4, alp_pkg::RCV_BCAST, 32'd20, 16'd0, 32'd5);
        directed(alp_pkg::OP_REQUEST, 16'd2, RCV_OTHER, 32'd21, 16'd0, 32'd0);
        directed(alp_pkg::OP_REQUEST, 16'd3, RCV_SPARE, 32'd21, 16'd0, 32'd0);
        directed(OP_OTHER, 16'd5, alp_pkg::RCV_BCAST, 32'd22, 16'd1, 32'd0);
        directed(OP_SPARE, 16'd5, alp_pkg::RCV_SELF, 32'd22, 16'd1, 32'd0);
        directed(alp_pkg::OP_DISCOVER, 16'd5, alp_pkg::RCV_SELF, 32'd23, 16'd0, 32'd0);
        directed(alp_pkg::OP_DISCOVER, 16'd5, RCV_OTHER, 32'd23, 16'd0, 32'd0);
        directed(alp_pkg::OP_REQUEST, 16'd5, alp_pkg::RCV_BCAST, 32'd23, 16'd1, 32'd0);
        directed(alp_pkg::OP_DISCOVER, 16'd5, alp_pkg::RCV_BCAST, 32'd200, 16'd0, 32'd0);
        directed(alp_pkg::OP_REQUEST, 16'd1, alp_pkg::RCV_SELF, 32'd201, 16'd1, 32'd0);
        directed(alp_pkg::OP_DISCOVER, 16'hFFFF, alp_pkg::RCV_BCAST, 32'hFFFF_FFFF,
                 16'd0, 32'd0);
        held = ledger.held_by(16'hFFFF);
        directed(alp_pkg::OP_REQUEST, 16'hFFFF, alp_pkg::RCV_SELF, 32'hFFFF_FFF0,
                 16'(held), 32'hFFFF_FFFF);
        directed(alp_pkg::OP_DISCOVER, 16'd0, alp_pkg::RCV_BCAST, 32'hFFFF_FF00,
                 16'hFFFF, 32'hFFFF_FFF0);
        directed(alp_pkg::OP_REQUEST, 16'd1, alp_pkg::RCV_SELF, 32'hFFFF_FFFF,
                 16'd256, 32'd0);
        drain();

        // Tiny pool with short leases: runs out of free entries, reuses expired ones.
        clk_now = '0;
        load_cfg(9'd4, 32'd5, 32'd20, 32'd2);
        run_phase(150, 1, 5, 4, 40);

        // Single entry, extreme lease bounds, hosts near the top of the id range.
        load_cfg(9'd1, 32'd1, 32'hFFFF_FFFF, 32'd1);
        run_phase(70, 16'hFFF8, 3, 3, 20);

        // Empty pool: discovers vanish, every request is refused.
        load_cfg(9'd0, 32'd100, 32'd1000, 32'd10);
        run_phase(20, 1, 4, 10, 100);

        // Count above the pool size acts as the full pool; minimum above maximum.
        load_cfg(9'd511, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
        run_phase(30, 1, 300, 1000, 4000);

        // Mid-sized pool with moderate leases and many hosts.
        load_cfg(9'd16, 32'd50, 32'd400, 32'd20);
        run_phase(200, 16'h0100, 20, 30, 500);

        // Odd pool size, tight window, hosts with the top id bit set.
        load_cfg(9'd7, 32'd3, 32'd8, 32'd3);
        run_phase(80, 16'h8000, 10, 2, 12);

        if (ledger.errors == 0 && ledger.outstanding() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

>>> filelist.f
rtl/alp_pkg.sv
rtl/alp_ram.sv
rtl/alp_lease.sv
rtl/address_lease_pool.sv
tb/tb.sv
